FILE: hw/rtl/lts_pkg.sv
// Shared types and constants for the lat-long texture sampler.
package lts_pkg;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_UV    = 2'd1,
        CMD_DIR   = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MODE   = 2'd2;

    localparam int CfgW = 13;

    // atan(2^-i) in Q0.32 turns
    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        case (i)
            5'd0:  atan_turns = 32'h20000000;
            5'd1:  atan_turns = 32'h12E4051E;
            5'd2:  atan_turns = 32'h09FB385B;
            5'd3:  atan_turns = 32'h051111D4;
            5'd4:  atan_turns = 32'h028B0D43;
            5'd5:  atan_turns = 32'h0145D7E1;
            5'd6:  atan_turns = 32'h00A2F61E;
            5'd7:  atan_turns = 32'h00517C55;
            5'd8:  atan_turns = 32'h0028BE53;
            5'd9:  atan_turns = 32'h00145F2F;
            5'd10: atan_turns = 32'h000A2F98;
            5'd11: atan_turns = 32'h000517CC;
            5'd12: atan_turns = 32'h00028BE6;
            5'd13: atan_turns = 32'h000145F3;
            5'd14: atan_turns = 32'h0000A2FA;
            5'd15: atan_turns = 32'h0000517D;
            5'd16: atan_turns = 32'h000028BE;
            5'd17: atan_turns = 32'h0000145F;
            5'd18: atan_turns = 32'h00000A30;
            5'd19: atan_turns = 32'h00000518;
            5'd20: atan_turns = 32'h0000028C;
            5'd21: atan_turns = 32'h00000146;
            5'd22: atan_turns = 32'h000000A3;
            5'd23: atan_turns = 32'h00000051;
            default: atan_turns = 32'h0;
        endcase
    endfunction

endpackage

FILE: hw/rtl/lts_ram.sv
// Generic single-port RAM with registered read.
module lts_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: hw/rtl/latlong_texture_sampler.sv
// Top level of the lat-long nearest-texel sampler.
// A write holds busy while the store is written. A uv sample runs two multiplies and one
// index multiply through one shared multiplier, then a store read; its result shows in the
// first cycle that busy is low. A direction sample first runs an azimuth CORDIC pass, then
// y*y, a bitwise square root and a polar CORDIC pass, each pass a setup step and its
// iterations, and then the uv steps. busy is high for the whole item. Each
// result shows on o_valid for one cycle and cannot be held off, so it must be taken when shown.
// Colors come out zero when the index reaches MAX_TEXELS.
module latlong_texture_sampler #(
    parameter int MAX_TEXELS   = 65536,
    parameter int CORDIC_STEPS = 16,
    parameter int CHANNELS     = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_texel_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic signed [23:0] i_coord_u,
    input  logic signed [23:0] i_coord_v,
    input  logic signed [15:0] i_dir_x,
    input  logic signed [15:0] i_dir_y,
    input  logic signed [15:0] i_dir_z,
    output logic        o_valid,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out,
    output logic [23:0] o_fetched_index,
    output logic        o_index_overflow
);
    import lts_pkg::*;

    localparam int AW    = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
    localparam int DW    = CHANNELS * 8;
    localparam int SW    = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS + 1) : 1;
    localparam logic [SW-1:0] LastStep = SW'(CORDIC_STEPS - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_WRITE = 11'b00000000010,
        S_YSQ   = 11'b00000000100,
        S_SQRT  = 11'b00000001000,
        S_CPRE  = 11'b00000010000,
        S_CITER = 11'b00000100000,
        S_COL   = 11'b00001000000,
        S_ROW   = 11'b00010000000,
        S_IDX   = 11'b00100000000,
        S_READ  = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    logic [12:0] r_width, r_height;
    logic        r_mode;

    logic [AW-1:0] r_waddr;
    logic [DW-1:0] r_wdata;
    logic [15:0] r_u, r_v;
    logic signed [15:0] r_dx, r_dy, r_dz;
    logic        r_pass;           // 0 azimuth, 1 polar
    logic [SW-1:0] r_step;
    logic signed [34:0] r_cx, r_cy;
    logic [31:0] r_ang;
    logic [31:0] r_rem, r_res, r_bit;
    logic [4:0]  r_sq;
    logic [31:0] r_prod;
    logic [12:0] r_row;
    logic [25:0] r_idx;
    logic        r_ovf;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [47:0] mul_p;
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_YSQ:   begin
                mul_a = 32'(unsigned'(r_dy[15] ? -32'(r_dy) : 32'(r_dy)));
                mul_b = mul_a;
            end
            S_COL:   begin
                mul_a = {16'd0, r_u};
                mul_b = {19'd0, (r_width == 13'd0) ? 13'd0 : r_width - 13'd1};
            end
            S_ROW:   begin
                mul_a = {16'd0, r_v};
                mul_b = {19'd0, (r_height == 13'd0) ? 13'd0 : r_height - 13'd1};
            end
            S_IDX:   begin
                mul_a = {19'd0, r_row};
                mul_b = {19'd0, r_width};
            end
            default: ;
        endcase
        mul_p = 48'(mul_a[23:0]) * 48'(mul_b[23:0]);
    end

    // CORDIC step
    logic signed [34:0] sh_x, sh_y;
    logic [31:0] at;
    logic [31:0] ang_nx;
    always_comb begin
        sh_x   = r_cx >>> r_step;
        sh_y   = r_cy >>> r_step;
        at     = atan_turns(5'(r_step));
        ang_nx = (r_cy >= 0) ? r_ang + at : r_ang - at;
    end

    logic [31:0] sq_try;
    assign sq_try = r_res + r_bit;

    logic [DW-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    assign ram_we   = (r_state == S_WRITE);
    assign ram_addr = (r_state == S_WRITE) ? r_waddr : AW'(r_idx);

    lts_ram #(.WIDTH(DW), .DEPTH(MAX_TEXELS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(r_wdata),
        .o_rdata(ram_rdata)
    );

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) begin
                case (t_cmd'(i_cmd))
                    // writes beyond the store are dropped
                    CMD_WRITE: n_state = ({16'd0, i_texel_index} < 32'(MAX_TEXELS)) ?
                                         S_WRITE : S_IDLE;
                    CMD_UV:    n_state = S_COL;
                    CMD_DIR:   n_state = S_CPRE;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_WRITE: n_state = S_IDLE;
            S_YSQ:   n_state = S_SQRT;
            S_SQRT:  if (r_sq == 5'd15) n_state = S_CPRE;
            S_CPRE:  n_state = S_CITER;
            S_CITER: if (r_step == LastStep) n_state = r_pass ? S_COL : S_YSQ;
            S_COL:   n_state = S_ROW;
            S_ROW:   n_state = S_IDX;
            S_IDX:   n_state = S_READ;
            S_READ:  n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_width  <= 13'd256;
            r_height <= 13'd256;
            r_mode   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_OUT);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  r_width  <= i_cfg_data;
                    REG_HEIGHT: r_height <= i_cfg_data;
                    REG_MODE:   r_mode   <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    logic signed [34:0] pre_x, pre_y;
    logic [31:0] pre_a;
    logic signed [34:0] in_x, in_y;
    logic [31:0] az, v33;
    always_comb begin
        in_x = r_pass ? 35'(r_dy) <<< 8 : 35'(r_dz) <<< 8;
        in_y = r_pass ? $signed({3'b000, r_res[31:0]}) <<< 8 : 35'(r_dx) <<< 8;
        pre_x = in_x;
        pre_y = in_y;
        pre_a = 32'd0;
        if (in_x < 0) begin
            if (in_y >= 0) begin
                pre_x = in_y; pre_y = -in_x; pre_a = 32'h40000000;
            end else begin
                pre_x = -in_y; pre_y = in_x; pre_a = 32'hC0000000;
            end
        end
        // angle after the final iteration
        az  = ang_nx + 32'h80000000;
        v33 = {ang_nx[30:0], 1'b0};
    end

    logic [15:0] up;
    assign up = 16'((33'(az) + 33'h8000) >> 16);

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_waddr <= AW'(i_texel_index);
                r_wdata <= DW'({i_red_in, i_green_in, i_blue_in});
                r_u     <= i_coord_u[15:0];
                r_v     <= i_coord_v[15:0];
                r_dx    <= i_dir_x;
                r_dy    <= i_dir_y;
                r_dz    <= i_dir_z;
                r_pass  <= 1'b0;
            end
            S_YSQ: begin
                r_rem <= 32'h40000000 - mul_p[31:0];
                r_res <= '0;
                r_bit <= 32'h40000000;
                r_sq  <= '0;
            end
            S_SQRT: begin
                r_sq <= r_sq + 5'd1;
                if (r_rem >= sq_try) begin
                    r_rem <= r_rem - sq_try;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            S_CPRE: begin
                r_cx   <= pre_x;
                r_cy   <= pre_y;
                r_ang  <= pre_a;
                r_step <= '0;
            end
            S_CITER: begin
                r_step <= r_step + SW'(1);
                r_ang  <= ang_nx;
                if (r_cy >= 0) begin
                    r_cx <= r_cx + sh_y; r_cy <= r_cy - sh_x;
                end else begin
                    r_cx <= r_cx - sh_y; r_cy <= r_cy + sh_x;
                end
                if (r_step == LastStep) begin
                    if (!r_pass) begin
                        r_u    <= r_mode ? 16'(16'd0 - up) : 16'(17'h10000 - 17'(up));
                        r_pass <= 1'b1;
                    end else begin
                        r_v <= 16'((33'(v33) + 33'h8000) >> 16);
                    end
                end
            end
            S_COL: r_prod <= 32'(mul_p + 48'h8000) >> 16;
            S_ROW: r_row  <= 13'((mul_p + 48'h8000) >> 16);
            S_IDX: begin
                r_idx <= 26'(mul_p) + 26'(r_prod);
                r_ovf <= (26'(mul_p) + 26'(r_prod)) >= 26'(MAX_TEXELS);
            end
            default: ;
        endcase
    end

    // result registers load in S_OUT; colors are forced to zero on index overflow
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT) begin
            o_red_out        <= r_ovf ? 8'd0 : ram_rdata[23:16];
            o_green_out      <= r_ovf ? 8'd0 : ram_rdata[15:8];
            o_blue_out       <= r_ovf ? 8'd0 : ram_rdata[7:0];
            o_fetched_index  <= r_idx[23:0];
            o_index_overflow <= r_ovf;
        end
    end
endmodule

FILE: hw/rtl/lts_checker.sv
// Port-level checks for the lat-long texture sampler.
module lts_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic [7:0] o_red_out,
    input logic o_index_overflow
);
    a_idle_rst: assert property (@(posedge i_clk) !i_rst_n |=> !busy && !o_valid)
        else $error("not idle after reset");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || !o_valid)
        else $error("accept not seen");
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result longer than a cycle");
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_overflow |-> o_red_out == 8'd0)
        else $error("color on overflow");
endmodule

bind latlong_texture_sampler lts_checker u_lts_checker (.*);

FILE: tb/testbench.sv
// Self-checking testbench for the lat-long nearest-texel sampler.
`timescale 1ns / 1ps

module testbench;
    import lts_pkg::*;

    localparam int STORE_DEPTH = 65536;
    localparam int ANGLE_STEPS = 16;
    localparam int SETTLE_CYCLES = 80;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int PHASE_ITEMS = 150;

    typedef struct {
        t_cmd               cmd;
        logic [15:0]        tidx;
        logic [7:0]         r, g, b;
        logic signed [23:0] u, v;
        logic signed [15:0] x, y, z;
    } texel_cmd_t;

    typedef struct {
        logic [7:0]  r, g, b;
        logic [23:0] idx;
        logic        ovf;
    } texel_result_t;

    // one directed step: a register write or an item, optionally with a typed result
    typedef struct {
        bit            is_cfg;
        logic [1:0]    reg_sel;
        logic [12:0]   reg_val;
        texel_cmd_t    item;
        bit            typed;
        texel_result_t res;
    } step_t;

    localparam logic [31:0] ATAN_TURNS [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic [1:0]  i_cmd = '0;
    logic [15:0] i_texel_index = '0;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic signed [23:0] i_coord_u = '0, i_coord_v = '0;
    logic signed [15:0] i_dir_x = '0, i_dir_y = '0, i_dir_z = '0;
    logic        o_valid;
    logic [7:0]  o_red_out, o_green_out, o_blue_out;
    logic [23:0] o_fetched_index;
    logic        o_index_overflow;

    latlong_texture_sampler u_top (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [23:0]   texels [STORE_DEPTH];
    bit            texel_written [STORE_DEPTH];
    logic [12:0]   width_reg = 13'd256;
    logic [12:0]   height_reg = 13'd256;
    logic          mode_reg = 1'b0;
    texel_result_t pending_texels [$];
    int            mismatches = 0;
    int            item_count = 0;
    int            idle_pct = 0;
    longint        cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] vector_turns(longint num, longint den);
        longint x, y, t, dx, dy;
        logic [31:0] ang;
        x = den * 256;
        y = num * 256;
        ang = '0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; ang = 32'h40000000;
            end else begin
                x = -y; y = t; ang = 32'hC0000000;
            end
        end
        for (int i = 0; i < ANGLE_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += ATAN_TURNS[i];
            end else begin
                x -= dx; y += dy; ang -= ATAN_TURNS[i];
            end
        end
        return ang;
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [31:0] v);
        logic [31:0] res, bitv;
        res = '0;
        bitv = 32'h40000000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // linear index the item would fetch under the current registers
    function automatic longint fetch_index(texel_cmd_t it);
        logic [15:0] u16, v16, up;
        logic [31:0] az, root, pol;
        logic [32:0] v33;
        logic [63:0] tmp;
        longint ys, w, h, wm1, hm1, col, row;
        if (it.cmd == CMD_UV) begin
            u16 = it.u[15:0];
            v16 = it.v[15:0];
        end else begin
            az = vector_turns(longint'(it.x), longint'(it.z)) + 32'h80000000;
            tmp = ({32'b0, az} + 64'h8000) >> 16;
            up = tmp[15:0];
            ys = longint'(it.y);
            root = floor_sqrt(32'((longint'(1) << 30) - ys * ys));
            pol = vector_turns(longint'(root), ys);
            v33 = {pol, 1'b0};
            tmp = ({31'b0, v33} + 64'h8000) >> 16;
            v16 = tmp[15:0];
            if (mode_reg)
                u16 = 16'h0 - up;
            else
                u16 = 16'(17'h10000 - 17'(up));
        end
        w = longint'(width_reg);
        h = longint'(height_reg);
        wm1 = (w != 0) ? w - 1 : 0;
        hm1 = (h != 0) ? h - 1 : 0;
        col = (longint'(u16) * wm1 + 32768) >> 16;
        row = (longint'(v16) * hm1 + 32768) >> 16;
        return row * w + col;
    endfunction

    function automatic texel_result_t predict_texel(texel_cmd_t it);
        texel_result_t res;
        longint idx;
        idx = fetch_index(it);
        res.idx = idx[23:0];
        res.ovf = (idx >= STORE_DEPTH);
        {res.r, res.g, res.b} = res.ovf ? 24'h0 : texels[idx];
        return res;
    endfunction

    always @(posedge i_clk) begin
        texel_result_t want;
        if (i_rst_n && o_valid) begin
            if (pending_texels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result idx=%0d", o_fetched_index);
            end else begin
                want = pending_texels.pop_front();
                if (o_red_out !== want.r || o_green_out !== want.g ||
                        o_blue_out !== want.b || o_fetched_index !== want.idx ||
                        o_index_overflow !== want.ovf) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp rgb=%h%h%h idx=%0d ovf=%b, got rgb=%h%h%h idx=%0d ovf=%b",
                                 want.r, want.g, want.b, want.idx, want.ovf, o_red_out,
                                 o_green_out, o_blue_out, o_fetched_index, o_index_overflow);
                end
            end
        end
    end

    task automatic send_item(texel_cmd_t it, bit typed, texel_result_t res);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_cmd = it.cmd;
        i_texel_index = it.tidx;
        i_red_in = it.r;
        i_green_in = it.g;
        i_blue_in = it.b;
        i_coord_u = it.u;
        i_coord_v = it.v;
        i_dir_x = it.x;
        i_dir_y = it.y;
        i_dir_z = it.z;
        do @(posedge i_clk); while (busy);
        if (it.cmd == CMD_WRITE) begin
            texels[it.tidx] = {it.r, it.g, it.b};
            texel_written[it.tidx] = 1'b1;
        end else if (it.cmd != CMD_NONE) begin
            pending_texels.push_back(typed ? res : predict_texel(it));
        end
    endtask

    // a sample never reads a texel that was not written: fill it first
    task automatic fill_if_needed(texel_cmd_t it);
        texel_cmd_t wr;
        texel_result_t none;
        longint idx;
        none = '{default: '0};
        if (it.cmd == CMD_UV || it.cmd == CMD_DIR) begin
            idx = fetch_index(it);
            if (idx < STORE_DEPTH && !texel_written[idx]) begin
                wr = it;
                wr.cmd = CMD_WRITE;
                wr.tidx = idx[15:0];
                wr.r = 8'($urandom); wr.g = 8'($urandom); wr.b = 8'($urandom);
                send_item(wr, 1'b0, none);
            end
        end
    endtask

    task automatic set_register(logic [1:0] sel, logic [12:0] val);
        @(negedge i_clk);
        start = 1'b0;
        while (pending_texels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = sel;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (sel)
            REG_WIDTH:  width_reg = val;
            REG_HEIGHT: height_reg = val;
            REG_MODE:   mode_reg = val[0];
            default: ;
        endcase
    endtask

    function automatic logic signed [15:0] rand_dir();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    step_t directed [26] = '{
        '{0, 0, 0, '{CMD_WRITE, 16'd0, 8'h11, 8'h22, 8'h33, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_WRITE, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0, 0, 0}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_WRITE, 16'd255, 8'h00, 8'h80, 8'h01, 0, 0, 0, 0, 0}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'h0, 24'h0, 0, 0, 0}, 1,
          '{8'h11, 8'h22, 8'h33, 24'd0, 1'b0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0}, 1,
          '{8'hFF, 8'hFF, 8'hFF, 24'd65535, 1'b0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'h7FFFFF, 24'h800000, 0, 0, 0}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'h008000, 24'h008000, 0, 0, 0}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h7FFF, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h8000, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h7FFF, 16'h0000, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h0000, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 16'h8000}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h5A82, 16'h0000, 16'h5A82}, 0,
          '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_NONE, 16'h1234, 8'h55, 8'hAA, 8'h0F, 24'h123, 24'h456, 16'h7, 16'h8,
          16'h9}, 0, '{0, 0, 0, 0, 0}},
        '{1, REG_MODE, 13'd1, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_DIR, 0, 0, 0, 0, 0, 0, 16'h8000, 16'h0000, 16'h0000}, 0,
          '{0, 0, 0, 0, 0}},
        '{1, REG_WIDTH, 13'd4096, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{1, REG_HEIGHT, 13'd4096, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0}, 1,
          '{8'h00, 8'h00, 8'h00, 24'hFFFFFF, 1'b1}},
        '{1, REG_WIDTH, 13'd0, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{1, REG_HEIGHT, 13'd0, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'h123456, 24'hABCDEF, 0, 0, 0}, 1,
          '{8'h11, 8'h22, 8'h33, 24'd0, 1'b0}},
        '{1, REG_WIDTH, 13'd8191, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{1, REG_HEIGHT, 13'd1, '{CMD_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0}, 0, '{0, 0, 0, 0, 0}},
        '{0, 0, 0, '{CMD_UV, 0, 0, 0, 0, 24'h000000, 24'hFFFFFF, 0, 0, 0}, 1,
          '{8'h11, 8'h22, 8'h33, 24'd0, 1'b0}}
    };

    // random phases: width, height, map mode
    logic [12:0] phase_w [6] = '{13'd256, 13'd1, 13'd4096, 13'd0, 13'd37, 13'd4096};
    logic [12:0] phase_h [6] = '{13'd256, 13'd4096, 13'd16, 13'd7, 13'd200, 13'd4096};
    logic        phase_m [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    initial begin
        texel_cmd_t it;
        int kind;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            if (directed[k].is_cfg) begin
                set_register(directed[k].reg_sel, directed[k].reg_val);
            end else begin
                fill_if_needed(directed[k].item);
                send_item(directed[k].item, directed[k].typed, directed[k].res);
            end
        end

        for (int p = 0; p < 6; p++) begin
            set_register(REG_WIDTH, phase_w[p]);
            set_register(REG_HEIGHT, phase_h[p]);
            set_register(REG_MODE, {12'b0, phase_m[p]});
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                idle_pct = (item_count < 300) ? 31 : (item_count < 600) ? 67 : 0;
                kind = $urandom_range(99);
                it.tidx = 16'($urandom);
                it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom);
                it.u = 24'($urandom); it.v = 24'($urandom);
                it.x = rand_dir(); it.y = rand_dir(); it.z = rand_dir();
                if (kind < 30) it.cmd = CMD_WRITE;
                else if (kind < 64) it.cmd = CMD_UV;
                else if (kind < 98) it.cmd = CMD_DIR;
                else it.cmd = CMD_NONE;
                fill_if_needed(it);
                send_item(it, 1'b0, '{default: '0});
                item_count++;
            end
        end

        @(negedge i_clk);
        start = 1'b0;
        while (pending_texels.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/lts_pkg.sv
hw/rtl/lts_ram.sv
hw/rtl/latlong_texture_sampler.sv
hw/rtl/lts_checker.sv
tb/testbench.sv
